// ----- rtl/h2r_pkg.sv -----
// shared constants, types and channel arithmetic for the hls to rgb converter
`default_nettype none

package h2r_pkg;

  // fixed point: ONE stands for 1.0
  localparam int FRAC_BITS = 15;
  localparam int LW        = FRAC_BITS + 1;
  localparam logic [LW-1:0] ONE  = LW'(64'(1) << FRAC_BITS);
  localparam logic [LW-1:0] HALF = LW'(64'(1) << (FRAC_BITS - 1));

  localparam int FIELD_W = 16;

  // hue in 1/64 degree: one turn and one 60 degree sector
  localparam int HUE_W = 15;
  localparam int SEC_W = 12;
  localparam logic [FIELD_W-1:0] HUE_TURN   = 16'd23040;
  localparam logic [SEC_W-1:0]   HUE_SECTOR = 12'd3840;
  localparam logic [SEC_W-1:0]   HUE_HALF   = 12'd1920;

  // x = (c * g + 1920) / 3840, done as (p >> 8) / 15
  localparam int P_W   = LW + 11;
  localparam int N_W   = P_W - 8;
  localparam int Q_W   = N_W - 3;
  localparam logic [Q_W-1:0] RECIP = Q_W'((64'(1) << N_W) / 15);
  localparam logic [N_W-1:0] DIVISOR = N_W'(15);

  // first letter holds chroma, second letter holds the secondary term
  typedef enum logic [2:0] {
    SEC_RG,
    SEC_GR,
    SEC_GB,
    SEC_BG,
    SEC_BR,
    SEC_RB
  } sector_e;

  // (2p + 2l - c + 1) >> 1, floored at zero and clamped to ONE
  function automatic logic [FIELD_W-1:0] chan_value(logic [LW-1:0] p, logic [LW-1:0] l,
                                                    logic [LW-1:0] c);
    logic [LW+1:0] twice;
    logic [LW+1:0] diff;
    logic [LW+1:0] v;
    twice = {1'b0, p, 1'b0} + {1'b0, l, 1'b0};
    diff  = twice - (LW+2)'(c);
    v     = (diff + (LW+2)'(1)) >> 1;
    if (twice < (LW+2)'(c)) begin
      return '0;
    end else if (v > (LW+2)'(ONE)) begin
      return FIELD_W'(ONE);
    end else begin
      return FIELD_W'(v);
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/h2r_div15.sv -----
// two stage divide by fifteen: reciprocal multiply, then one correction step
`default_nettype none

module h2r_div15
  import h2r_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [N_W-1:0] num_i,
  output logic      [Q_W-1:0] quo_o
);

  logic [N_W-1:0]     num_q;
  logic [Q_W-1:0]     est_q;
  logic [Q_W-1:0]     est_d;
  logic [N_W+Q_W-1:0] prod;
  logic [N_W-1:0]     rem;
  logic [Q_W-1:0]     quo_q;
  logic [Q_W-1:0]     quo_d;

  // estimate is the true quotient or one below it
  assign prod  = (N_W+Q_W)'(num_i) * (N_W+Q_W)'(RECIP);
  assign est_d = Q_W'(prod >> N_W);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_i;
      est_q <= est_d;
    end
  end

  assign rem   = num_q - N_W'(est_q) * DIVISOR;
  assign quo_d = (rem >= DIVISOR) ? est_q + Q_W'(1) : est_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/hls_to_rgb_converter.sv -----
// hsl to rgb conversion: hue in 1/64 degree, lightness and saturation in q1.15
// usage:
//   input channel carries hue_i, lightness_i, saturation_i under in_valid_i and
//   in_ready_o; output channel carries red_o, green_o, blue_o under out_valid_o
//   and out_ready_i. one word out for every word in, in order.
//   a word passes seven register stages, the first of which loads at the
//   accepting edge: hue wrap and lightness fold, chroma multiply, chroma
//   rounding, secondary multiply, two stages of divide by 3840, and the
//   channel offset and clamp.
//   throughput is one word per cycle while the receiver takes words.
//   when out_ready_i is low with a word waiting, the whole pipeline holds and
//   in_ready_o drops; nothing is lost or repeated. bubbles move up whenever the
//   output register is empty or being taken.
//   reset clears all valid bits; the block has no state beyond the pipeline.
`default_nettype none

module hls_to_rgb_converter
  import h2r_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FIELD_W-1:0] hue_i,
  input  wire logic [FIELD_W-1:0] lightness_i,
  input  wire logic [FIELD_W-1:0] saturation_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [FIELD_W-1:0] red_o,
  output logic      [FIELD_W-1:0] green_o,
  output logic      [FIELD_W-1:0] blue_o
);

  localparam int STAGES = 7;

  logic              advance;
  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] valid_d;

  assign advance    = !valid_q[STAGES-1] || out_ready_i;
  assign in_ready_o = advance;
  assign valid_d    = {valid_q[STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= valid_d;
    end
  end

  // stage 1: hue wrap, clamp lightness and saturation, fold lightness
  logic [HUE_W-1:0] h1_d, h1_q;
  logic [LW-1:0]    l1_d, l1_q, s1_d, s1_q, om1_d, om1_q;
  logic [LW:0]      twol, fold;

  always_comb begin
    if (hue_i >= {HUE_TURN[FIELD_W-2:0], 1'b0}) begin
      h1_d = HUE_W'(hue_i - {HUE_TURN[FIELD_W-2:0], 1'b0});
    end else if (hue_i >= HUE_TURN) begin
      h1_d = HUE_W'(hue_i - HUE_TURN);
    end else begin
      h1_d = HUE_W'(hue_i);
    end
    l1_d = (32'(lightness_i) > 32'(ONE)) ? ONE : LW'(lightness_i);
    s1_d = (32'(saturation_i) > 32'(ONE)) ? ONE : LW'(saturation_i);
    twol = {l1_d, 1'b0};
    fold = (twol >= (LW+1)'(ONE)) ? twol - (LW+1)'(ONE) : (LW+1)'(ONE) - twol;
    om1_d = LW'((LW+1)'(ONE) - fold);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      h1_q  <= h1_d;
      l1_q  <= l1_d;
      s1_q  <= s1_d;
      om1_q <= om1_d;
    end
  end

  // stage 2: chroma product, sector and triangular fraction
  logic [2*LW-1:0]  prod2_d, prod2_q;
  sector_e          sec2_d, sec2_q;
  logic [HUE_W-1:0] base2;
  logic [SEC_W-1:0] f2;
  logic [SEC_W-1:0] g2_d, g2_q;
  logic [LW-1:0]    l2_q;
  logic             odd2;

  assign prod2_d = (2*LW)'(om1_q) * (2*LW)'(s1_q);

  always_comb begin
    if (h1_q >= HUE_W'(5 * HUE_SECTOR)) begin
      sec2_d = SEC_RB;
      base2  = HUE_W'(5 * HUE_SECTOR);
    end else if (h1_q >= HUE_W'(4 * HUE_SECTOR)) begin
      sec2_d = SEC_BR;
      base2  = HUE_W'(4 * HUE_SECTOR);
    end else if (h1_q >= HUE_W'(3 * HUE_SECTOR)) begin
      sec2_d = SEC_BG;
      base2  = HUE_W'(3 * HUE_SECTOR);
    end else if (h1_q >= HUE_W'(2 * HUE_SECTOR)) begin
      sec2_d = SEC_GB;
      base2  = HUE_W'(2 * HUE_SECTOR);
    end else if (h1_q >= HUE_W'(HUE_SECTOR)) begin
      sec2_d = SEC_GR;
      base2  = HUE_W'(HUE_SECTOR);
    end else begin
      sec2_d = SEC_RG;
      base2  = '0;
    end
    f2   = SEC_W'(h1_q - base2);
    odd2 = (sec2_d == SEC_GR) || (sec2_d == SEC_BG) || (sec2_d == SEC_RB);
    g2_d = odd2 ? HUE_SECTOR - f2 : f2;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod2_q <= prod2_d;
      sec2_q  <= sec2_d;
      g2_q    <= g2_d;
      l2_q    <= l1_q;
    end
  end

  // stage 3: round chroma
  logic [LW-1:0]    c3_q, l3_q;
  logic [SEC_W-1:0] g3_q;
  sector_e          sec3_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c3_q   <= LW'((prod2_q + (2*LW)'(HALF)) >> FRAC_BITS);
      g3_q   <= g2_q;
      sec3_q <= sec2_q;
      l3_q   <= l2_q;
    end
  end

  // stage 4: secondary numerator
  logic [P_W-1:0] p4_q;
  logic [LW-1:0]  c4_q, l4_q;
  sector_e        sec4_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p4_q   <= P_W'(c3_q) * P_W'(g3_q) + P_W'(HUE_HALF);
      c4_q   <= c3_q;
      sec4_q <= sec3_q;
      l4_q   <= l3_q;
    end
  end

  // stages 5 and 6: divide by 3840
  logic [Q_W-1:0] x6;
  logic [LW-1:0]  c5_q, l5_q, c6_q, l6_q;
  sector_e        sec5_q, sec6_q;

  h2r_div15 u_div (
    .clk_i (clk_i),
    .en_i  (advance),
    .num_i (p4_q[P_W-1:8]),
    .quo_o (x6)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c5_q   <= c4_q;
      l5_q   <= l4_q;
      sec5_q <= sec4_q;
      c6_q   <= c5_q;
      l6_q   <= l5_q;
      sec6_q <= sec5_q;
    end
  end

  // stage 7: route terms, add offset, clamp
  logic [LW-1:0]      x6w;
  logic [LW-1:0]      pr, pg, pb;
  logic [FIELD_W-1:0] red_q, green_q, blue_q;

  assign x6w = LW'(x6);

  always_comb begin
    pr = '0;
    pg = '0;
    pb = '0;
    case (sec6_q)
      SEC_RG: begin
        pr = c6_q;
        pg = x6w;
      end
      SEC_GR: begin
        pr = x6w;
        pg = c6_q;
      end
      SEC_GB: begin
        pg = c6_q;
        pb = x6w;
      end
      SEC_BG: begin
        pg = x6w;
        pb = c6_q;
      end
      SEC_BR: begin
        pr = x6w;
        pb = c6_q;
      end
      SEC_RB: begin
        pr = c6_q;
        pb = x6w;
      end
      default: begin
        pr = '0;
        pg = '0;
        pb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      red_q   <= chan_value(pr, l6_q, c6_q);
      green_q <= chan_value(pg, l6_q, c6_q);
      blue_q  <= chan_value(pb, l6_q, c6_q);
    end
  end

  assign out_valid_o = valid_q[STAGES-1];
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

`ifndef SYNTHESIS
  // secondary term never exceeds chroma
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[5] |-> (32'(x6) <= 32'(c6_q)))
    else $error("secondary term above chroma");

  // results stay within 0..1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(red_o) <= 32'(ONE) && 32'(green_o) <= 32'(ONE) &&
                     32'(blue_o) <= 32'(ONE)))
    else $error("channel out of range");

  // a stall freezes every valid bit in the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(valid_q))
    else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

// ----- tb/hls_to_rgb_converter_tb.sv -----
// self-checking testbench for the hls to rgb converter: directed corners, then random colors
`default_nettype none

module hls_to_rgb_converter_tb;
  import h2r_pkg::*;

  localparam longint UNIT = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] hue = '0;
  logic [FIELD_W-1:0] lightness = '0;
  logic [FIELD_W-1:0] saturation = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] red;
  logic [FIELD_W-1:0] green;
  logic [FIELD_W-1:0] blue;

  rgb_word_t pending_rgb[$];
  int        errors = 0;
  bit        throttle = 1'b1;

  hls_to_rgb_converter dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .hue_i        (hue),
    .lightness_i  (lightness),
    .saturation_i (saturation),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // offset by l - c/2, rounded half up, floored at zero and clamped to one
  function automatic logic [FIELD_W-1:0] offset_channel(longint prim, longint lit,
                                                        longint chroma);
    longint twice;
    twice = 2 * prim + 2 * lit - chroma;
    if (twice < 0) begin
      return '0;
    end
    twice = (twice + 1) >>> 1;
    if (twice > UNIT) begin
      twice = UNIT;
    end
    return FIELD_W'(twice);
  endfunction

  function automatic rgb_word_t hsl_to_rgb(logic [FIELD_W-1:0] h_in, logic [FIELD_W-1:0] l_in,
                                           logic [FIELD_W-1:0] s_in);
    longint    h, lit, sat, fold, chroma, sector_len, frac, ramp, sec_x;
    longint    pr, pg, pb;
    sector_e   sec;
    rgb_word_t rgb;
    sector_len = longint'(HUE_SECTOR);
    h      = longint'(h_in) % longint'(HUE_TURN);
    lit    = (longint'(l_in) > UNIT) ? UNIT : longint'(l_in);
    sat    = (longint'(s_in) > UNIT) ? UNIT : longint'(s_in);
    fold   = (2 * lit >= UNIT) ? 2 * lit - UNIT : UNIT - 2 * lit;
    chroma = ((UNIT - fold) * sat + UNIT / 2) >>> FRAC_BITS;
    frac   = h % sector_len;
    // falling edge of the triangle in odd sectors
    ramp   = ((h / sector_len) % 2 == 1) ? sector_len - frac : frac;
    sec_x  = (chroma * ramp + sector_len / 2) / sector_len;
    sec    = sector_e'(3'(h / sector_len));
    pr = 0;
    pg = 0;
    pb = 0;
    case (sec)
      SEC_RG: begin pr = chroma; pg = sec_x; end
      SEC_GR: begin pr = sec_x;  pg = chroma; end
      SEC_GB: begin pg = chroma; pb = sec_x; end
      SEC_BG: begin pg = sec_x;  pb = chroma; end
      SEC_BR: begin pr = sec_x;  pb = chroma; end
      default: begin pr = chroma; pb = sec_x; end
    endcase
    rgb.red   = offset_channel(pr, lit, chroma);
    rgb.green = offset_channel(pg, lit, chroma);
    rgb.blue  = offset_channel(pb, lit, chroma);
    return rgb;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!throttle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_hue();
    if ($urandom_range(0, 1) == 0) begin
      return FIELD_W'($urandom_range(0, 65535));
    end
    return FIELD_W'($urandom_range(0, 23039));
  endfunction

  function automatic logic [FIELD_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      return FIELD_W'($urandom_range(0, 32768));
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return FIELD_W'(UNIT);
        2: return FIELD_W'(UNIT / 2);
        default: return FIELD_W'(UNIT - 1);
      endcase
    end
    // full 16-bit range, values above one saturated by the block
    return FIELD_W'($urandom_range(0, 65535));
  endfunction

  // returns right after the accepting edge with valid still high
  task automatic send_color(input logic [FIELD_W-1:0] h, input logic [FIELD_W-1:0] l,
                            input logic [FIELD_W-1:0] s);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    lightness  <= l;
    saturation <= s;
    do @(posedge clk); while (!in_ready);
    pending_rgb.push_back(hsl_to_rgb(h, l, s));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_colors();
    throttle = 1'b1;
    send_color(16'd0,     16'd16384, 16'd32768);  // pure red
    send_color(16'd7680,  16'd16384, 16'd32768);  // pure green
    send_color(16'd15360, 16'd16384, 16'd32768);  // pure blue
    send_color(16'd1920,  16'd16384, 16'd32768);
    send_color(16'd5760,  16'd16384, 16'd32768);
    send_color(16'd9600,  16'd16384, 16'd32768);
    send_color(16'd13440, 16'd16384, 16'd32768);
    send_color(16'd17280, 16'd16384, 16'd32768);
    send_color(16'd21120, 16'd16384, 16'd32768);
    send_color(16'd3839,  16'd20000, 16'd30000);  // sector edges
    send_color(16'd3840,  16'd20000, 16'd30000);
    send_color(16'd11520, 16'd12000, 16'd25000);
    send_color(16'd19200, 16'd12000, 16'd25000);
    send_color(16'd23039, 16'd16384, 16'd32768);  // just below a full turn
    send_color(16'd23040, 16'd16384, 16'd32768);  // wraps to zero
    send_color(16'd65535, 16'd16384, 16'd32768);
    send_color(16'd4000,  16'd0,     16'd32768);  // black
    send_color(16'd4000,  16'd32768, 16'd32768);  // white
    send_color(16'd4000,  16'd20000, 16'd0);      // gray
    send_color(16'd9000,  16'd65535, 16'd65535);  // both above one
    send_color(16'd9000,  16'd32769, 16'd1);
    send_color(16'd17000, 16'd1,     16'd65535);
    send_color(16'd12345, 16'd32767, 16'd32767);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    throttle = 1'b0;
    for (int i = 0; i < 150; i++) begin
      send_color(pick_hue(), pick_level(), pick_level());
    end
    wait_drained();
  endtask

  task automatic test_random_colors();
    for (int i = 0; i < 1000; i++) begin
      if (i % 100 == 0) begin
        throttle = ($urandom_range(0, 3) != 0);
      end
      if (i == 500) begin
        wait_drained();
      end
      send_color(pick_hue(), pick_level(), pick_level());
    end
    wait_drained();
  endtask

  // receiver: takes words, with random stalls while throttled
  initial begin
    int stall_len;
    stall_len = 0;
    forever begin
      @(negedge clk);
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        stall_len--;
      end else begin
        out_ready <= 1'b1;
        if (throttle && $urandom_range(0, 3) == 0) begin
          stall_len = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin : check_colors
    rgb_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rgb.size() == 0) begin
        $error("unexpected word: red %0d green %0d blue %0d", red, green, blue);
        errors++;
      end else begin
        want = pending_rgb.pop_front();
        if (red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red);
          errors++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green);
          errors++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_corner_colors();
    test_back_to_back();
    test_random_colors();
    // catch any extra word coming out of the pipeline
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_rgb.size() == 0) begin
      $display("[hls_to_rgb_converter] OK");
    end else begin
      $display("[hls_to_rgb_converter] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[hls_to_rgb_converter] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
